FILE: rtl/plrf_pkg.sv
// ----------------------------------------------------------------------------
// plrf_pkg
// Types, fixed-point constants and helpers for the pair loss rate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package plrf_pkg;

  // Field and datapath widths
  localparam int K_W    = 48;  // argument k
  localparam int OUT_W  = 32;  // loss value
  localparam int P_W    = 6;   // leading-one position of k
  localparam int M_W    = 31;  // log mantissa, Q30 in [1,2)
  localparam int LF_W   = 30;  // log2 fraction bits, one per squaring step
  localparam int L2_W   = 36;  // binary log, Q30
  localparam int L_W    = 30;  // natural log (and u) operand, Q24
  localparam int U_W    = 29;  // u and k in Q24, low range
  localparam int U2_W   = 35;  // u^2 in Q24
  localparam int T_W    = 42;  // signed Horner accumulator, Q24
  localparam int Q1_W   = 30;  // quotient bits of the first divider
  localparam int R_W    = 25;  // 1/k in Q28
  localparam int LO_W   = 59;  // q^2 and then pi/12 q^2
  localparam int A_W    = 36;  // denominator correction, Q28
  localparam int D_W    = 29;  // 1 - correction, Q28
  localparam int QV_W   = 58;  // cubic / k, Q56
  localparam int V_W    = 42;  // result before output rounding, Q32
  localparam int DEN3_W = 32;  // divisor of the last divider

  // Coefficients, Q24 unless noted
  localparam logic signed [T_W-1:0] K_C1       = 42'sd13502303;
  localparam logic signed [T_W-1:0] K_C2       = 42'sd2447796;
  localparam logic signed [T_W-1:0] K_C3       = 42'sd19076;
  localparam logic signed [T_W-1:0] K_C4       = -42'sd65;
  localparam logic signed [T_W-1:0] K_D0       = -42'sd1444014981;
  localparam logic signed [T_W-1:0] K_D1       = 42'sd854966927;
  localparam logic signed [T_W-1:0] K_D2       = -42'sd242430771;
  localparam logic signed [T_W-1:0] K_D3       = 42'sd44739243;
  localparam logic signed [T_W-1:0] K_Q24_ONE  = 42'sd16777216;
  localparam logic [22:0]           K_PI12     = 23'd4392265;
  localparam logic [A_W-1:0]        K_F1       = 36'd781147177;    // Q28
  localparam logic [A_W-1:0]        K_F2       = 36'd21031917978;  // Q28
  localparam logic [A_W-1:0]        K_F3       = 36'd1837;
  localparam logic [27:0]           K_LN2      = 28'd186065279;    // Q28

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_LOW,
    CLS_HIGH
  } cls_e;

  // Input register
  typedef struct packed {
    cls_e             cls;
    logic [K_W-1:0]   kr;
    logic [P_W-1:0]   p;
    logic [U_W-1:0]   u;
    logic [U_W-1:0]   k24;
  } s1_t;

  // Logarithm squaring chain, low-range Horner rides along
  typedef struct packed {
    cls_e                   cls;
    logic [K_W-1:0]         kr;
    logic [P_W-1:0]         p;
    logic [M_W-1:0]         m;
    logic [LF_W-1:0]        f;
    logic [U_W-1:0]         u;
    logic [U_W-1:0]         k24;
    logic [U2_W-1:0]        u2;
    logic signed [T_W-1:0]  t;
  } log_t;

  // High-range cubic in ln k
  typedef struct packed {
    cls_e                   cls;
    logic [K_W-1:0]         kr;
    logic [U_W-1:0]         k24;
    logic [U2_W-1:0]        u2;
    logic signed [T_W-1:0]  den;
    logic [L_W-1:0]         l;
    logic signed [T_W-1:0]  t;
  } hc_t;

  typedef struct packed {
    cls_e                   cls;
    logic [K_W-1:0]         kr;
    logic signed [T_W-1:0]  den;
    logic signed [T_W-1:0]  c;
  } d1s_t;

  // Products after the first divider
  typedef struct packed {
    cls_e                   cls;
    logic [K_W-1:0]         kr;
    logic signed [T_W-1:0]  den;
    logic signed [T_W-1:0]  c;
    logic [R_W-1:0]         r;
    logic [LO_W-1:0]        lo;
    logic [A_W-1:0]         a;
    logic                   dsat;
    logic [D_W-1:0]         d;
  } ar_t;

  typedef struct packed {
    cls_e                   cls;
    logic signed [T_W-1:0]  den;
    logic [LO_W-1:0]        lo;
    logic                   dsat;
    logic [D_W-1:0]         d;
    logic                   cpos;
  } d2s_t;

  typedef struct packed {
    logic force_sat;
    logic force_zero;
  } d3s_t;

  // Unsigned x times signed t, shifted right by 24, rounded half away from zero
  function automatic logic signed [T_W-1:0] smul24(input logic [L_W-1:0] x,
                                                    input logic signed [T_W-1:0] t);
    logic [T_W-1:0]       tm;
    logic [L_W+T_W-1:0]   pr;
    logic [T_W-1:0]       rm;
    tm = t[T_W-1] ? T_W'(-t) : T_W'(t);
    pr = (L_W+T_W)'(x) * (L_W+T_W)'(tm) + ((L_W+T_W)'(1) << 23);
    rm = T_W'(pr >> 24);
    return t[T_W-1] ? -$signed(rm) : $signed(rm);
  endfunction

  // Horner coefficients of the low-range denominator, step 1 first
  function automatic logic signed [T_W-1:0] lowc(input int i);
    logic signed [T_W-1:0] v;
    case (i)
      1:       v = K_C2;
      2:       v = K_C1;
      default: v = K_Q24_ONE;
    endcase
    return v;
  endfunction

  // Horner coefficients of the high-range cubic, step 1 first
  function automatic logic signed [T_W-1:0] highc(input int j);
    logic signed [T_W-1:0] v;
    case (j)
      1:       v = K_D2;
      2:       v = K_D1;
      default: v = K_D0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/plrf_div.sv
// ----------------------------------------------------------------------------
// plrf_div
// Pipelined restoring divider: one quotient bit per stage, rounded half up.
// ----------------------------------------------------------------------------
`default_nettype none

module plrf_div #(
  parameter int NUM_W  = 60,
  parameter int DEN_W  = 48,
  parameter int QUO_W  = 30,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,   // round(num / 2 / den)
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  nq_q   [QUO_W];
  logic [DEN_W-1:0]  dv_q   [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [QUO_W-1:0]  vld_q;

  // Advance valid bits with the stall enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  nq_in;
    logic [DEN_W-1:0]  dv_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (j == 0) begin : g_head
      assign rem_in  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign nq_in   = num_i[QUO_W-1:0];
      assign dv_in   = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign rem_in  = rem_q[j-1];
      assign nq_in   = nq_q[j-1];
      assign dv_in   = dv_q[j-1];
      assign side_in = side_q[j-1];
    end

    // Shift in one dividend bit, subtract when it fits
    assign trial = {rem_in, nq_in[QUO_W-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[j]   <= {nq_in[QUO_W-2:0], ge};
        dv_q[j]   <= dv_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = QUO_W'(({1'b0, nq_q[QUO_W-1]} + (QUO_W+1)'(1)) >> 1);
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/pair_loss_rate_function.sv
// ----------------------------------------------------------------------------
// pair_loss_rate_function
// Piecewise fitted pair-production loss rate F(k), fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                    | tuser
//  s_axis    | in        | [47:0] k_value           | -
//  m_axis    | out       | [31:0] loss_value        | [0] saturated
//
//  One item enters per cycle while m_axis is not stalled. The pipeline
//  is made up mainly of the 30 log squaring stages and the three restoring
//  dividers (30, 58 and 42 quotient bits, one bit per stage).
//  Reset clears only the valid bits. A stall on m_axis freezes the whole
//  pipeline; s_axis_tready follows the output register's free state.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_loss_rate_function #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [47:0] k_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] loss_value
  output logic [0:0]  m_axis_tuser    // [0] saturated
);

  import plrf_pkg::*;

  localparam int SH     = OUT_W - OUT_FRAC_BITS;
  localparam int N1_W   = (U2_W + 25 > 30 + IN_FRAC_BITS) ? U2_W + 25 : 30 + IN_FRAC_BITS;
  localparam int N2_W   = (T_W - 1) + IN_FRAC_BITS + 33;
  localparam int N3_W   = LO_W + 9;
  localparam logic [63:0] TWO_K  = 64'(2) << IN_FRAC_BITS;
  localparam logic [63:0] LIM_K  = 64'(25) << IN_FRAC_BITS;
  localparam logic [V_W:0] HALF  = (V_W+1)'((64'(1) << SH) >> 1);

  logic adv;

  // Whole pipeline moves when the output register is free or drained
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // --------------------------------------------------------------------------
  // Input stage: classify, find leading one, form u and k in Q24
  // --------------------------------------------------------------------------
  s1_t  s1_d, s1_q;
  logic s1_vld_q;

  always_comb begin
    logic [K_W-1:0] kr;
    kr        = s_axis_tdata[K_W-1:0];
    s1_d.kr   = kr;
    s1_d.p    = '0;
    for (int i = 0; i < K_W; i++) begin
      if (kr[i]) s1_d.p = P_W'(i);
    end
    if (64'(kr) <= TWO_K) begin
      s1_d.cls = CLS_ZERO;
    end else if (64'(kr) < LIM_K) begin
      s1_d.cls = CLS_LOW;
    end else begin
      s1_d.cls = CLS_HIGH;
    end
    s1_d.u   = U_W'((64'(kr) - TWO_K) << (24 - IN_FRAC_BITS));
    s1_d.k24 = U_W'(64'(kr) << (24 - IN_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // Normalize mantissa, start low-range Horner and u^2
  // --------------------------------------------------------------------------
  log_t            log_q [LF_W+1];
  logic [LF_W:0]   log_vld_q;
  log_t            log0_d;

  always_comb begin
    logic [P_W-1:0] dn;
    logic [P_W-1:0] up;
    dn            = s1_q.p - P_W'(30);
    up            = P_W'(30) - s1_q.p;
    log0_d.cls    = s1_q.cls;
    log0_d.kr     = s1_q.kr;
    log0_d.p      = s1_q.p;
    log0_d.m      = (s1_q.p >= P_W'(30)) ? M_W'(s1_q.kr >> dn) : M_W'(s1_q.kr << up);
    log0_d.f      = '0;
    log0_d.u      = s1_q.u;
    log0_d.k24    = s1_q.k24;
    log0_d.u2     = U2_W'((64'(s1_q.u) * 64'(s1_q.u) + (64'(1) << 23)) >> 24);
    log0_d.t      = K_C3 + smul24(L_W'(s1_q.u), K_C4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) log_q[0] <= log0_d;
  end

  // Squaring steps: one binary-log fraction bit each
  for (genvar i = 1; i <= LF_W; i++) begin : g_log
    log_t nx;
    always_comb begin
      logic [2*M_W+1:0] sq;
      nx = log_q[i-1];
      sq = ((2*M_W+2)'(log_q[i-1].m) * (2*M_W+2)'(log_q[i-1].m)
            + ((2*M_W+2)'(1) << (LF_W - 1))) >> LF_W;
      if (sq[M_W]) begin
        nx.m             = sq[M_W:1];
        nx.f[LF_W - i]   = 1'b1;
      end else begin
        nx.m = sq[M_W-1:0];
      end
      if (i <= 3) begin
        nx.t = lowc(i) + smul24(L_W'(log_q[i-1].u), log_q[i-1].t);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) log_q[i] <= nx;
    end
  end

  // --------------------------------------------------------------------------
  // Natural log, then the cubic in ln k
  // --------------------------------------------------------------------------
  hc_t        hc_q [4];
  logic [3:0] hc_vld_q;
  hc_t        hc0_d;

  always_comb begin
    logic [L2_W-1:0] l2;
    l2        = ((L2_W'(log_q[LF_W].p) - L2_W'(IN_FRAC_BITS)) << LF_W)
                | L2_W'(log_q[LF_W].f);
    hc0_d.cls = log_q[LF_W].cls;
    hc0_d.kr  = log_q[LF_W].kr;
    hc0_d.k24 = log_q[LF_W].k24;
    hc0_d.u2  = log_q[LF_W].u2;
    hc0_d.den = log_q[LF_W].t;
    hc0_d.l   = L_W'((72'(l2) * 72'(K_LN2) + (72'(1) << 33)) >> 34);
    hc0_d.t   = K_D3;
  end

  always_ff @(posedge clk_i) begin
    if (adv) hc_q[0] <= hc0_d;
  end

  for (genvar j = 1; j <= 3; j++) begin : g_hc
    hc_t nx;
    always_comb begin
      nx   = hc_q[j-1];
      nx.t = highc(j) + smul24(hc_q[j-1].l, hc_q[j-1].t);
    end
    always_ff @(posedge clk_i) begin
      if (adv) hc_q[j] <= nx;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: q = u^2 / k (low range) or r = 1 / k (high range)
  // --------------------------------------------------------------------------
  logic [N1_W-1:0] d1_num;
  logic [K_W-1:0]  d1_den;
  d1s_t            d1_side_in, d1_side_out;
  logic            d1_vld;
  logic [Q1_W-1:0] d1_quo;

  always_comb begin
    if (hc_q[3].cls == CLS_LOW) begin
      d1_num = N1_W'(hc_q[3].u2) << 25;
      d1_den = K_W'(hc_q[3].k24);
    end else begin
      d1_num = N1_W'(1) << (29 + IN_FRAC_BITS);
      d1_den = hc_q[3].kr;
    end
    d1_side_in.cls = hc_q[3].cls;
    d1_side_in.kr  = hc_q[3].kr;
    d1_side_in.den = hc_q[3].den;
    d1_side_in.c   = hc_q[3].t;
  end

  plrf_div #(
    .NUM_W  (N1_W),
    .DEN_W  (K_W),
    .QUO_W  (Q1_W),
    .SIDE_W ($bits(d1s_t))
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (hc_vld_q[3]),
    .num_i   (d1_num),
    .den_i   (d1_den),
    .side_i  (d1_side_in),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side_out)
  );

  // --------------------------------------------------------------------------
  // Products: q^2 and pi/12 q^2, or the 1/k correction series
  // --------------------------------------------------------------------------
  ar_t        ar_q [3];
  logic [2:0] ar_vld_q;
  ar_t        ar0_d, ar1_d, ar2_d;

  always_comb begin
    ar0_d      = '0;
    ar0_d.cls  = d1_side_out.cls;
    ar0_d.kr   = d1_side_out.kr;
    ar0_d.den  = d1_side_out.den;
    ar0_d.c    = d1_side_out.c;
    ar0_d.r    = R_W'(d1_quo);
    ar0_d.lo   = LO_W'((64'(d1_quo) * 64'(d1_quo) + (64'(1) << 23)) >> 24);
    ar0_d.a    = K_F2 + K_F3 * A_W'(R_W'(d1_quo));
  end

  always_comb begin
    ar1_d    = ar_q[0];
    ar1_d.lo = LO_W'(64'(K_PI12) * 64'(ar_q[0].lo));
    ar1_d.a  = A_W'(64'(K_F1)
                    + ((64'(ar_q[0].a) * 64'(ar_q[0].r) + (64'(1) << 27)) >> 28));
  end

  always_comb begin
    logic [63:0] a3;
    a3         = (64'(ar_q[1].a) * 64'(ar_q[1].r) + (64'(1) << 27)) >> 28;
    ar2_d      = ar_q[1];
    ar2_d.a    = A_W'(a3);
    ar2_d.dsat = a3 >= (64'(1) << 28);
    ar2_d.d    = D_W'((64'(1) << 28) - a3);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ar_q[0] <= ar0_d;
      ar_q[1] <= ar1_d;
      ar_q[2] <= ar2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: cubic / k in Q56
  // --------------------------------------------------------------------------
  logic [N2_W-1:0] d2_num;
  d2s_t            d2_side_in, d2_side_out;
  logic            d2_vld;
  logic [QV_W-1:0] d2_quo;
  logic            cpos;

  assign cpos   = !ar_q[2].c[T_W-1] && (ar_q[2].c != '0);
  assign d2_num = cpos ? (N2_W'(ar_q[2].c[T_W-2:0]) << (IN_FRAC_BITS + 33)) : '0;

  always_comb begin
    d2_side_in.cls  = ar_q[2].cls;
    d2_side_in.den  = ar_q[2].den;
    d2_side_in.lo   = ar_q[2].lo;
    d2_side_in.dsat = ar_q[2].dsat;
    d2_side_in.d    = ar_q[2].d;
    d2_side_in.cpos = cpos;
  end

  plrf_div #(
    .NUM_W  (N2_W),
    .DEN_W  (K_W),
    .QUO_W  (QV_W),
    .SIDE_W ($bits(d2s_t))
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ar_vld_q[2]),
    .num_i   (d2_num),
    .den_i   (ar_q[2].kr),
    .side_i  (d2_side_in),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side_out)
  );

  // --------------------------------------------------------------------------
  // Divider 3: final quotient for either range, in Q32
  // --------------------------------------------------------------------------
  logic [N3_W-1:0]   d3_num;
  logic [DEN3_W-1:0] d3_den;
  d3s_t              d3_side_in, d3_side_out;
  logic              d3_vld;
  logic [V_W-1:0]    d3_quo;

  always_comb begin
    logic is_low;
    logic is_high;
    logic den_bad;
    is_low  = d2_side_out.cls == CLS_LOW;
    is_high = d2_side_out.cls == CLS_HIGH;
    den_bad = d2_side_out.den[T_W-1] || (d2_side_out.den == '0);
    if (is_low) begin
      d3_num = N3_W'(d2_side_out.lo) << 9;
      d3_den = d2_side_out.den[DEN3_W-1:0];
    end else begin
      d3_num = N3_W'(d2_quo) << 5;
      d3_den = DEN3_W'(d2_side_out.d);
    end
    d3_side_in.force_sat  = (is_low && den_bad) || (is_high && d2_side_out.dsat);
    d3_side_in.force_zero = (!is_low && !is_high)
                            || (is_high && !d2_side_out.dsat && !d2_side_out.cpos);
  end

  plrf_div #(
    .NUM_W  (N3_W),
    .DEN_W  (DEN3_W),
    .QUO_W  (V_W),
    .SIDE_W ($bits(d3s_t))
  ) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d2_vld),
    .num_i   (d3_num),
    .den_i   (d3_den),
    .side_i  (d3_side_in),
    .valid_o (d3_vld),
    .quo_o   (d3_quo),
    .side_o  (d3_side_out)
  );

  // --------------------------------------------------------------------------
  // Output: round to the output format, saturate, hold until transfer
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] loss_d, loss_q;
  logic             sat_d, sat_q;
  logic             out_vld_q;

  always_comb begin
    logic [V_W:0] vs;
    vs = ((V_W+1)'(d3_quo) + HALF) >> SH;
    if (d3_side_out.force_sat) begin
      loss_d = '1;
      sat_d  = 1'b1;
    end else if (d3_side_out.force_zero) begin
      loss_d = '0;
      sat_d  = 1'b0;
    end else if (vs > (V_W+1)'({OUT_W{1'b1}})) begin
      loss_d = '1;
      sat_d  = 1'b1;
    end else begin
      loss_d = vs[OUT_W-1:0];
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      loss_q <= loss_d;
      sat_q  <= sat_d;
    end
  end

  // Valid bits of the stages outside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      log_vld_q <= '0;
      hc_vld_q  <= '0;
      ar_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= s_axis_tvalid;
      log_vld_q <= {log_vld_q[LF_W-1:0], s1_vld_q};
      hc_vld_q  <= {hc_vld_q[2:0], log_vld_q[LF_W]};
      ar_vld_q  <= {ar_vld_q[1:0], d1_vld};
      out_vld_q <= d3_vld;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = loss_q;
  assign m_axis_tuser[0] = sat_q;

endmodule

`default_nettype wire
